[rtl/core/odo_pkg.sv]
// ----------------------------------------------------------------------------
// odo_pkg
// shared constants, types and tables of the wheel odometry block
// ----------------------------------------------------------------------------
package odo_pkg;

    localparam int CordicSteps = 16;
    localparam int SumW        = 32;
    localparam int CfgW        = 24;
    localparam int CfgIdxW     = 1;
    localparam int IterW       = $clog2(CordicSteps + 1);
    localparam int QueueDepth  = 2;
    localparam int QPtrW       = $clog2(QueueDepth);

    localparam logic [CfgIdxW-1:0] REG_MPT = 1'b0;
    localparam logic [CfgIdxW-1:0] REG_IBW = 1'b1;

    localparam logic [CfgW-1:0] MptReset = 24'd1079445;
    localparam logic [CfgW-1:0] IbwReset = 24'd270810;

    localparam logic [1:0] ACT_LEFT  = 2'd0;
    localparam logic [1:0] ACT_RIGHT = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    localparam logic [31:0] QuarterTurn = 32'h4000_0000;
    localparam logic [31:0] HalfTurn    = 32'h8000_0000;
    localparam logic [29:0] InvTwoPiQ32 = 30'd683565276;
    localparam logic signed [33:0] CordicGain = 34'sd652032874;
    localparam logic [30:0] MagLimit = '1;

    typedef struct packed {
        logic signed [SumW:0] sum_s;
        logic signed [SumW:0] sum_d;
    } tick_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SMUL_LO, ST_SMUL_HI, ST_SFIN, ST_DMUL_LO, ST_DMUL_HI, ST_DFIN,
        ST_RAD, ST_WLO, ST_WHI, ST_WFIN, ST_C1_INIT, ST_C1_ITER, ST_XMUL, ST_XADD,
        ST_YMUL, ST_YADD, ST_C2_INIT, ST_C2_ITER, ST_EMIT
    } back_state_t;

    // binary-angle arctangent of 2^-i
    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0:  r = 32'd536870912;
                5'd1:  r = 32'd316933406;
                5'd2:  r = 32'd167458907;
                5'd3:  r = 32'd85004756;
                5'd4:  r = 32'd42667331;
                5'd5:  r = 32'd21354465;
                5'd6:  r = 32'd10679838;
                5'd7:  r = 32'd5340245;
                5'd8:  r = 32'd2670163;
                5'd9:  r = 32'd1335087;
                5'd10: r = 32'd667544;
                5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;
                5'd13: r = 32'd83443;
                5'd14: r = 32'd41722;
                5'd15: r = 32'd20861;
                5'd16: r = 32'd10430;
                5'd17: r = 32'd5215;
                5'd18: r = 32'd2608;
                5'd19: r = 32'd1304;
                5'd20: r = 32'd652;
                5'd21: r = 32'd326;
                5'd22: r = 32'd163;
                5'd23: r = 32'd81;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

[rtl/core/odo_cmd_if.sv]
// ----------------------------------------------------------------------------
// odo_cmd_if
// encoder and tick item channel
// ----------------------------------------------------------------------------
interface odo_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [15:0] count_delta;

    modport source (output valid, action, count_delta, input ready);
    modport sink   (input valid, action, count_delta, output ready);
endinterface

[rtl/core/odo_pose_if.sv]
// ----------------------------------------------------------------------------
// odo_pose_if
// pose result channel
// ----------------------------------------------------------------------------
interface odo_pose_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        heading;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;

    modport source (output valid, pos_x, pos_y, heading, quat_z, quat_w, input ready);
    modport sink   (input valid, pos_x, pos_y, heading, quat_z, quat_w, output ready);
endinterface

[rtl/core/differential_drive_odometry.sv]
// ----------------------------------------------------------------------------
// differential_drive_odometry
// differential-drive wheel odometry with cordic pose update
// ----------------------------------------------------------------------------
// encoder items (left or right count change) are taken one per cycle and only
// update the saturating count sums; they give no result. a tick item snapshots
// the sums into a two-entry queue and clears them, so encoder items keep
// flowing while the back end works. each tick yields one pose item after it
// leaves the queue, worked out by the back-end sequencer: mostly two 16-step
// cordic passes (heading, then half heading) plus the split multiplies for
// travel, heading change and position. the cmd channel stalls only while two
// ticks are already queued. configuration writes go to the two registers
// below and should happen only while no tick is in flight.
module differential_drive_odometry (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [odo_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [odo_pkg::CfgW-1:0]      cfg_data,
    odo_cmd_if.sink                       cmd,
    odo_pose_if.source                    pose
);
    // travel per count and inverse wheel base
    logic [odo_pkg::CfgW-1:0] mpt_reg;
    logic [odo_pkg::CfgW-1:0] ibw_reg;

    // front to queue, queue to back
    logic           q_push, q_full, q_pop, q_valid;
    odo_pkg::tick_t push_item, head_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mpt_reg <= odo_pkg::MptReset;
            ibw_reg <= odo_pkg::IbwReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                odo_pkg::REG_MPT: mpt_reg <= cfg_data;
                odo_pkg::REG_IBW: ibw_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // front end: count sums and tick snapshot
    odo_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (push_item)
    );

    odo_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (head_item)
    );

    // back end: pose integration and result register
    odo_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .mpt     (mpt_reg),
        .ibw     (ibw_reg),
        .q_valid (q_valid),
        .q_item  (head_item),
        .q_pop   (q_pop),
        .pose    (pose)
    );
endmodule

[rtl/core/odo_front.sv]
// ----------------------------------------------------------------------------
// odo_front
// accumulates encoder counts and turns each tick into a queued sum pair
// ----------------------------------------------------------------------------
module odo_front (
    input  logic              clk,
    input  logic              rst_n,
    odo_cmd_if.sink           cmd,
    input  logic              q_full,
    output logic              q_push,
    output odo_pkg::tick_t    q_item
);
    logic signed [odo_pkg::SumW-1:0] left_reg, left_next;
    logic signed [odo_pkg::SumW-1:0] right_reg, right_next;
    logic signed [odo_pkg::SumW:0]   left_ext, right_ext, add_sum;
    logic signed [odo_pkg::SumW-1:0] add_sat;
    logic                            accept;

    assign cmd.ready = !q_full;
    assign accept    = cmd.valid && cmd.ready;
    assign left_ext  = {left_reg[odo_pkg::SumW-1], left_reg};
    assign right_ext = {right_reg[odo_pkg::SumW-1], right_reg};

    always_comb
    begin
        add_sum = ((cmd.action == odo_pkg::ACT_RIGHT) ? right_ext : left_ext)
                  + (odo_pkg::SumW+1)'(cmd.count_delta);
        // saturate when the two top bits disagree
        if (add_sum[odo_pkg::SumW] != add_sum[odo_pkg::SumW-1])
        begin
            add_sat = {add_sum[odo_pkg::SumW], {(odo_pkg::SumW-1){!add_sum[odo_pkg::SumW]}}};
        end
        else
        begin
            add_sat = add_sum[odo_pkg::SumW-1:0];
        end
    end

    always_comb
    begin
        left_next    = left_reg;
        right_next   = right_reg;
        q_push       = 1'b0;
        q_item.sum_s = right_ext + left_ext;
        q_item.sum_d = right_ext - left_ext;
        if (accept)
        begin
            unique case (cmd.action)
                odo_pkg::ACT_LEFT:  left_next  = add_sat;
                odo_pkg::ACT_RIGHT: right_next = add_sat;
                odo_pkg::ACT_TICK:
                begin
                    q_push     = 1'b1;
                    left_next  = '0;
                    right_next = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= '0;
            right_reg <= '0;
        end
        else
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end
endmodule

[rtl/core/odo_queue.sv]
// ----------------------------------------------------------------------------
// odo_queue
// short tick queue between front and back
// ----------------------------------------------------------------------------
module odo_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  odo_pkg::tick_t    push_item,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output odo_pkg::tick_t    head
);
    localparam int CntW = $clog2(odo_pkg::QueueDepth + 1);

    odo_pkg::tick_t              mem_reg [odo_pkg::QueueDepth];
    logic [odo_pkg::QPtrW-1:0]   wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [CntW-1:0]             cnt_reg, cnt_next;

    assign full      = (cnt_reg == CntW'(odo_pkg::QueueDepth));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = pop  ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg + CntW'(push) - CntW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end
endmodule

[rtl/core/odo_back.sv]
// ----------------------------------------------------------------------------
// odo_back
// tick sequencer: travel, heading, cordic, position and quaternion
// ----------------------------------------------------------------------------
module odo_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [odo_pkg::CfgW-1:0]      mpt,
    input  logic [odo_pkg::CfgW-1:0]      ibw,
    input  logic                          q_valid,
    input  odo_pkg::tick_t                q_item,
    output logic                          q_pop,
    odo_pose_if.source                    pose
);
    localparam int MagW  = odo_pkg::SumW + 1;
    localparam int HiW   = MagW - 16;
    localparam int ProdW = MagW + odo_pkg::CfgW;

    odo_pkg::back_state_t state_reg, state_next;

    logic [MagW-1:0]                 mag_reg;
    logic [MagW-1:0]                 dmag_reg;
    logic                            s_neg_reg, d_neg_reg;
    logic [15+odo_pkg::CfgW:0]       plo_reg;
    logic [HiW+odo_pkg::CfgW-1:0]    phi_reg;
    logic signed [31:0]              v_reg;
    logic [30:0]                     q_reg;
    logic [54:0]                     rad_reg;
    logic [61:0]                     wlo_reg;
    logic [52:0]                     whi_reg;
    logic [31:0]                     head_reg;
    logic signed [31:0]              px_reg, py_reg;
    logic signed [33:0]              cx_reg, cy_reg, cz_reg;
    logic                            flip_reg;
    logic [odo_pkg::IterW-1:0]       it_reg;
    logic signed [65:0]              mprod_reg;
    logic                            out_valid_reg;
    logic signed [31:0]              out_x_reg, out_y_reg;
    logic [31:0]                     out_h_reg;
    logic signed [15:0]              out_z_reg, out_w_reg;

    logic [ProdW-1:0]        full_prod;
    logic [ProdW-1:0]        shifted;
    logic [30:0]             mag_sat;
    logic [31:0]             w_sum, w_signed;
    logic [31:0]             c_angle, c_t;
    logic                    c_flip;
    logic [4:0]              c_idx;
    logic signed [33:0]      c_xs, c_ys, c_atan;
    logic signed [33:0]      sn, cs;
    logic signed [37:0]      rnd, pos_sum;
    logic signed [31:0]      pos_old, pos_new;
    logic signed [33:0]      qz_r, qw_r;
    logic signed [15:0]      qz_sat, qw_sat;
    logic                    iter_last, out_free;

    assign pose.valid   = out_valid_reg;
    assign pose.pos_x   = out_x_reg;
    assign pose.pos_y   = out_y_reg;
    assign pose.heading = out_h_reg;
    assign pose.quat_z  = out_z_reg;
    assign pose.quat_w  = out_w_reg;
    assign out_free     = !out_valid_reg || pose.ready;

    // travel magnitude from the two partial products, saturated
    always_comb
    begin
        full_prod = {phi_reg, 16'b0} + ProdW'(plo_reg);
        shifted   = (state_reg == odo_pkg::ST_SFIN) ? (full_prod >> 17) : (full_prod >> 16);
        mag_sat   = (shifted > ProdW'(odo_pkg::MagLimit)) ? odo_pkg::MagLimit : shifted[30:0];
        w_sum     = whi_reg[31:0] + {2'b0, wlo_reg[61:32]};
        w_signed  = d_neg_reg ? (32'd0 - w_sum) : w_sum;
    end

    // cordic fold and micro-rotation
    always_comb
    begin
        c_angle = (state_reg == odo_pkg::ST_C2_INIT) ? {1'b0, head_reg[31:1]} : head_reg;
        c_flip  = ((c_angle - odo_pkg::QuarterTurn) < odo_pkg::HalfTurn);
        c_t     = c_flip ? c_angle + odo_pkg::HalfTurn : c_angle;
        c_idx   = 5'(it_reg);
        c_xs    = cx_reg >>> c_idx;
        c_ys    = cy_reg >>> c_idx;
        c_atan  = signed'({2'b0, odo_pkg::atan_entry(c_idx)});
        iter_last = (it_reg == odo_pkg::IterW'(odo_pkg::CordicSteps - 1));
        sn      = flip_reg ? -cy_reg : cy_reg;
        cs      = flip_reg ? -cx_reg : cx_reg;
    end

    // position accumulate with rounding and saturation
    always_comb
    begin
        pos_old = (state_reg == odo_pkg::ST_YADD) ? py_reg : px_reg;
        rnd     = 38'((mprod_reg + 66'sd536870912) >>> 30);
        pos_sum = rnd + 38'(pos_old);
        if (pos_sum > 38'sd2147483647)
        begin
            pos_new = 32'sh7fff_ffff;
        end
        else if (pos_sum < -38'sd2147483648)
        begin
            pos_new = 32'sh8000_0000;
        end
        else
        begin
            pos_new = pos_sum[31:0];
        end
    end

    // quaternion parts in q1.15
    always_comb
    begin
        qz_r = (sn + 34'sd16384) >>> 15;
        qw_r = (cs + 34'sd16384) >>> 15;
        if (qz_r > 34'sd32767)       qz_sat = 16'sh7fff;
        else if (qz_r < -34'sd32768) qz_sat = 16'sh8000;
        else                         qz_sat = qz_r[15:0];
        if (qw_r > 34'sd32767)       qw_sat = 16'sh7fff;
        else if (qw_r < -34'sd32768) qw_sat = 16'sh8000;
        else                         qw_sat = qw_r[15:0];
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            odo_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = odo_pkg::ST_SMUL_LO;
                end
            end
            odo_pkg::ST_SMUL_LO: state_next = odo_pkg::ST_SMUL_HI;
            odo_pkg::ST_SMUL_HI: state_next = odo_pkg::ST_SFIN;
            odo_pkg::ST_SFIN:    state_next = odo_pkg::ST_DMUL_LO;
            odo_pkg::ST_DMUL_LO: state_next = odo_pkg::ST_DMUL_HI;
            odo_pkg::ST_DMUL_HI: state_next = odo_pkg::ST_DFIN;
            odo_pkg::ST_DFIN:    state_next = odo_pkg::ST_RAD;
            odo_pkg::ST_RAD:     state_next = odo_pkg::ST_WLO;
            odo_pkg::ST_WLO:     state_next = odo_pkg::ST_WHI;
            odo_pkg::ST_WHI:     state_next = odo_pkg::ST_WFIN;
            odo_pkg::ST_WFIN:    state_next = odo_pkg::ST_C1_INIT;
            odo_pkg::ST_C1_INIT: state_next = odo_pkg::ST_C1_ITER;
            odo_pkg::ST_C1_ITER: if (iter_last) state_next = odo_pkg::ST_XMUL;
            odo_pkg::ST_XMUL:    state_next = odo_pkg::ST_XADD;
            odo_pkg::ST_XADD:    state_next = odo_pkg::ST_YMUL;
            odo_pkg::ST_YMUL:    state_next = odo_pkg::ST_YADD;
            odo_pkg::ST_YADD:    state_next = odo_pkg::ST_C2_INIT;
            odo_pkg::ST_C2_INIT: state_next = odo_pkg::ST_C2_ITER;
            odo_pkg::ST_C2_ITER: if (iter_last) state_next = odo_pkg::ST_EMIT;
            odo_pkg::ST_EMIT:    if (out_free) state_next = odo_pkg::ST_IDLE;
            default:             state_next = odo_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            odo_pkg::ST_IDLE:
            begin
                s_neg_reg <= q_item.sum_s[MagW-1];
                d_neg_reg <= q_item.sum_d[MagW-1];
                mag_reg   <= q_item.sum_s[MagW-1] ? MagW'(-q_item.sum_s)
                                                  : MagW'(q_item.sum_s);
                dmag_reg  <= q_item.sum_d[MagW-1] ? MagW'(-q_item.sum_d)
                                                  : MagW'(q_item.sum_d);
            end
            odo_pkg::ST_SMUL_LO, odo_pkg::ST_DMUL_LO: plo_reg <= mag_reg[15:0] * mpt;
            odo_pkg::ST_SMUL_HI, odo_pkg::ST_DMUL_HI: phi_reg <= mag_reg[MagW-1:16] * mpt;
            odo_pkg::ST_SFIN:
            begin
                v_reg   <= s_neg_reg ? -signed'({1'b0, mag_sat}) : signed'({1'b0, mag_sat});
                mag_reg <= dmag_reg;
            end
            odo_pkg::ST_DFIN:    q_reg   <= mag_sat;
            odo_pkg::ST_RAD:     rad_reg <= q_reg * ibw;
            odo_pkg::ST_WLO:     wlo_reg <= rad_reg[31:0] * odo_pkg::InvTwoPiQ32;
            odo_pkg::ST_WHI:     whi_reg <= rad_reg[54:32] * odo_pkg::InvTwoPiQ32;
            odo_pkg::ST_C1_INIT, odo_pkg::ST_C2_INIT:
            begin
                cx_reg   <= odo_pkg::CordicGain;
                cy_reg   <= '0;
                cz_reg   <= signed'({{2{c_t[31]}}, c_t});
                flip_reg <= c_flip;
                it_reg   <= '0;
            end
            odo_pkg::ST_C1_ITER, odo_pkg::ST_C2_ITER:
            begin
                if (!cz_reg[33])
                begin
                    cx_reg <= cx_reg - c_ys;
                    cy_reg <= cy_reg + c_xs;
                    cz_reg <= cz_reg - c_atan;
                end
                else
                begin
                    cx_reg <= cx_reg + c_ys;
                    cy_reg <= cy_reg - c_xs;
                    cz_reg <= cz_reg + c_atan;
                end
                it_reg <= it_reg + 1'b1;
            end
            odo_pkg::ST_XMUL:    mprod_reg <= v_reg * cs;
            odo_pkg::ST_YMUL:    mprod_reg <= v_reg * sn;
            odo_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_x_reg <= px_reg;
                    out_y_reg <= py_reg;
                    out_h_reg <= head_reg;
                    out_z_reg <= qz_sat;
                    out_w_reg <= qw_sat;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= odo_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == odo_pkg::ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pose.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // pose state lives here; reset clears it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            px_reg   <= '0;
            py_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                odo_pkg::ST_WFIN: head_reg <= head_reg + w_signed;
                odo_pkg::ST_XADD: px_reg   <= pos_new;
                odo_pkg::ST_YADD: py_reg   <= pos_new;
                default: ;
            endcase
        end
    end
endmodule

[bench/odo_pose_checker.sv]
// ----------------------------------------------------------------------------
// odo_pose_checker
// watches the cmd, config and pose channels, predicts each pose and compares
// ----------------------------------------------------------------------------
module odo_pose_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [odo_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [odo_pkg::CfgW-1:0]    cfg_data,
    odo_cmd_if                          cmd,
    odo_pose_if                         pose,
    output int                          fail_count,
    output int                          pending
);
    import odo_pkg::*;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [31:0]        hd;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
    } pose_t;

    localparam logic [31:0] ArcTab [0:23] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
    };
    localparam longint SumHi = (longint'(1) <<< (SumW - 1)) - 1;
    localparam longint SumLo = -SumHi - 1;

    logic [CfgW-1:0] mpt, ibw;
    longint          left_acc, right_acc;
    logic [31:0]     hdg;
    logic signed [31:0] px, py;
    pose_t           pose_q [$];
    int              shown;

    function automatic longint sat_sum(input longint v);
        return v > SumHi ? SumHi : (v < SumLo ? SumLo : v);
    endfunction

    function automatic logic signed [31:0] sat32(input longint v);
        return v > 64'sd2147483647 ? 32'sh7fffffff
             : (v < -64'sd2147483648 ? 32'sh80000000 : v[31:0]);
    endfunction

    function automatic longint unsigned scale_mag(input longint unsigned m,
                                                  input logic [CfgW-1:0] b,
                                                  input int sh);
        longint unsigned p;
        p = (m * b) >> sh;
        return p > 64'd2147483647 ? 64'd2147483647 : p;
    endfunction

    // sine and cosine of a binary angle, Q1.30
    function automatic void sin_cos(input logic [31:0] a, output longint sn,
                                    output longint cs);
        logic [31:0] t;
        logic        flip;
        longint      x, y, z, nx;
        t = a;
        flip = 1'b0;
        x = 64'sd652032874;
        y = 0;
        if (t - QuarterTurn < HalfTurn)
        begin
            t = t + HalfTurn;
            flip = 1'b1;
        end
        z = $signed(t);
        for (int i = 0; i < CordicSteps && i < 24; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(ArcTab[i]);
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(ArcTab[i]);
            end
            x = nx;
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endfunction

    function automatic logic signed [15:0] to_q15(input longint v);
        longint r;
        r = (v + 64'sd16384) >>> 15;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    // one tick: integrate the sums into heading, position and quaternion, then clear them
    function automatic pose_t integrate_tick();
        longint          s, d, v, sn, cs;
        longint unsigned q, rad, w;
        pose_t           p;
        s = right_acc + left_acc;
        d = right_acc - left_acc;
        v = scale_mag(s < 0 ? -s : s, mpt, 17);
        if (s < 0) v = -v;
        q = scale_mag(d < 0 ? -d : d, mpt, 16);
        rad = q * ibw;
        w = ((rad >> 32) * 64'd683565276
            + (((rad & 64'hFFFF_FFFF) * 64'd683565276) >> 32)) & 64'hFFFF_FFFF;
        if (d < 0) w = (64'd0 - w) & 64'hFFFF_FFFF;
        hdg = hdg + w[31:0];
        sin_cos(hdg, sn, cs);
        px = sat32(longint'(px) + ((v * cs + 64'sd536870912) >>> 30));
        py = sat32(longint'(py) + ((v * sn + 64'sd536870912) >>> 30));
        p.x = px;
        p.y = py;
        p.hd = hdg;
        sin_cos({1'b0, hdg[31:1]}, sn, cs);
        p.qz = to_q15(sn);
        p.qw = to_q15(cs);
        left_acc = 0;
        right_acc = 0;
        return p;
    endfunction

    function automatic void report(input string what, input longint exp_v,
                                   input longint act_v);
        fail_count++;
        if (shown < 10)
        begin
            shown++;
            $display("pose mismatch %s: expected %0d got %0d", what, exp_v, act_v);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pose_t e;
        if (!rst_n)
        begin
            mpt = MptReset;
            ibw = IbwReset;
            left_acc = 0;
            right_acc = 0;
            hdg = '0;
            px = '0;
            py = '0;
            pose_q.delete();
            fail_count = 0;
            pending = 0;
            shown = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_MPT) mpt = cfg_data;
                else if (cfg_index == REG_IBW) ibw = cfg_data;
            end
            if (pose.valid && pose.ready)
            begin
                if (pose_q.size() == 0)
                begin
                    fail_count++;
                    if (shown < 10)
                    begin
                        shown++;
                        $display("pose item with none expected: heading %0h",
                                 pose.heading);
                    end
                end
                else
                begin
                    e = pose_q.pop_front();
                    if (pose.pos_x !== e.x) report("pos_x", e.x, pose.pos_x);
                    if (pose.pos_y !== e.y) report("pos_y", e.y, pose.pos_y);
                    if (pose.heading !== e.hd) report("heading", e.hd, pose.heading);
                    if (pose.quat_z !== e.qz) report("quat_z", e.qz, pose.quat_z);
                    if (pose.quat_w !== e.qw) report("quat_w", e.qw, pose.quat_w);
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                case (cmd.action)
                    ACT_LEFT:  left_acc = sat_sum(left_acc + longint'(cmd.count_delta));
                    ACT_RIGHT: right_acc = sat_sum(right_acc + longint'(cmd.count_delta));
                    ACT_TICK:  pose_q.push_back(integrate_tick());
                    default:   ;
                endcase
            end
            pending = pose_q.size();
        end
    end
endmodule

[bench/tb_differential_drive_odometry.sv]
// ----------------------------------------------------------------------------
// tb_differential_drive_odometry
// drives encoder and tick items through several register settings and idle
// patterns; a side checker predicts every pose and the top gives the verdict
// ----------------------------------------------------------------------------
module tb_differential_drive_odometry;
    import odo_pkg::*;

    localparam int CycleLimit  = 600000;
    localparam int PhaseItems  = 300;
    localparam int DrainCycles = 150;

    logic            clk;
    logic            rst_n;
    logic            cfg_we;
    logic [CfgIdxW-1:0] cfg_index;
    logic [CfgW-1:0] cfg_data;
    int              fail_count;
    int              pending;
    int              cycles;
    int              idle_pct;
    int              stall_pct;
    int              sent;

    odo_cmd_if  cmd_ch ();
    odo_pose_if pose_ch ();

    differential_drive_odometry u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .pose      (pose_ch)
    );

    odo_pose_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd_ch),
        .pose       (pose_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 20 unit clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // hard stop if the block hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // pose receiver, stalls at the phase's rate
    always @(negedge clk)
        pose_ch.ready = ($urandom_range(99) >= stall_pct);

    // one item on the cmd channel, with random idle cycles ahead of it
    task automatic push_item(input logic [1:0] act, input logic signed [15:0] dlt);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            cmd_ch.valid = 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid = 1'b1;
        cmd_ch.action = act;
        cmd_ch.count_delta = dlt;
        do @(posedge clk); while (!cmd_ch.ready);
        if (act != 2'd3) sent++;
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // stop sending and let every pose come back
    task automatic drain();
        @(negedge clk);
        cmd_ch.valid = 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // count change: often small, sometimes an extreme, sometimes any value
    function automatic logic signed [15:0] pick_delta();
        int r;
        r = $urandom_range(99);
        if (r < 12)
            return ($urandom_range(1) != 0) ? 16'sh7fff : 16'sh8000;
        else if (r < 60)
            return 16'($urandom_range(2000)) - 16'sd1000;
        else
            return 16'($urandom);
    endfunction

    // a well-formed burst: encoder changes then a tick; straight bursts give
    // both wheels the same change so travel piles up toward saturation
    task automatic drive_burst(input int straight_pct);
        int               n;
        logic             straight;
        logic signed [15:0] dlt;
        n = $urandom_range(6);
        straight = ($urandom_range(99) < straight_pct);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < 4)
                push_item(2'd3, 16'($urandom));
            else if (straight)
            begin
                dlt = ($urandom_range(3) == 0) ? pick_delta() : 16'sh7fff;
                push_item(ACT_LEFT, dlt);
                push_item(ACT_RIGHT, dlt);
            end
            else
                push_item($urandom_range(1) ? ACT_RIGHT : ACT_LEFT, pick_delta());
        end
        // occasionally leave the sums running into the next burst
        if ($urandom_range(99) < 90)
            push_item(ACT_TICK, 16'($urandom));
    endtask

    initial
    begin
        logic [CfgW-1:0] mpt_val, ibw_val;
        int              bias;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_MPT;
        cfg_data = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.action = ACT_LEFT;
        cmd_ch.count_delta = '0;
        pose_ch.ready = 1'b0;
        cycles = 0;
        idle_pct = 0;
        stall_pct = 0;
        sent = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: count extremes, empty tick, unused action, unit counts
        push_item(ACT_LEFT, 16'sh7fff);
        push_item(ACT_RIGHT, 16'sh8000);
        push_item(ACT_TICK, 16'sh0000);
        push_item(ACT_LEFT, 16'sh8000);
        push_item(ACT_RIGHT, 16'sh7fff);
        push_item(ACT_TICK, 16'shffff);
        push_item(ACT_TICK, 16'sh5a5a);
        push_item(2'd3, 16'sh7fff);
        push_item(2'd3, 16'sh8000);
        push_item(ACT_LEFT, 16'sh0001);
        push_item(ACT_TICK, 16'sh0000);
        push_item(ACT_RIGHT, 16'shffff);
        push_item(ACT_TICK, 16'sh0000);
        push_item(ACT_LEFT, 16'sh7fff);
        push_item(ACT_RIGHT, 16'sh7fff);
        push_item(ACT_TICK, 16'sh0000);
        push_item(ACT_LEFT, 16'sh8000);
        push_item(ACT_RIGHT, 16'sh8000);
        push_item(ACT_TICK, 16'sh0000);
        drain();

        // random phases, each with its register settings and idle pattern
        for (int ph = 0; ph < 5; ph++)
        begin
            bias = 20;
            case (ph)
                0:
                begin
                    mpt_val = MptReset;
                    ibw_val = IbwReset;
                end
                1:
                begin
                    // largest travel and turn rate: wraps the heading, and
                    // straight runs push the position into saturation
                    mpt_val = '1;
                    ibw_val = '1;
                    bias = 70;
                end
                2:
                begin
                    // zero travel and zero inverse base: the pose stands still
                    mpt_val = '0;
                    ibw_val = '0;
                end
                3:
                begin
                    mpt_val = CfgW'($urandom);
                    ibw_val = 24'd1;
                end
                default:
                begin
                    mpt_val = 24'hFFFFFF;
                    ibw_val = CfgW'($urandom);
                    bias = 60;
                end
            endcase
            write_reg(REG_MPT, mpt_val);
            write_reg(REG_IBW, ibw_val);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 74; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 74; end
                default: begin idle_pct = 30; stall_pct = 30; end
            endcase
            sent = 0;
            while (sent < PhaseItems)
                drive_burst(bias);
            // make sure the phase leaves no count sums for the next settings
            push_item(ACT_TICK, 16'sh0000);
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
